/* src/odd_even_partition_defines.svh */
// Assertion macros for the odd/even partition block.
`ifndef ODD_EVEN_PARTITION_DEFINES_SVH
`define ODD_EVEN_PARTITION_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define OEP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define OEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OEP_ASSERT(label, clk, rst_n, prop, msg)
`define OEP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/oep_pkg.sv */
// Shared constants for the odd/even partition block.
`timescale 1ns / 1ps
`default_nettype none

package oep_pkg;
    localparam int WORD_W    = 32;
    localparam int DEPTH_DEF = 64;
endpackage

`default_nettype wire

/* src/odd_even_partition.sv */
// Top level: loads a run of words, partitions odd before even in place, streams it out.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------
//  input   | word_valid / word_ready | word, is_last
//  output  | res_valid / res_ready   | word_res, end_of_run, overflowed
//
// Load: one request per cycle; word_ready is high only in the load phase.
// Partition walk: each pointer step reads both entries, then tests their low
//   bits. A swap writes the low entry in the test cycle and the high entry in
//   the next cycle, moving both pointers.
// Emit: each word is a buffer read, then the held result.
// Reset clears the FSM, fill count and overflow flag; buffer contents are
//   not cleared. A stalled result simply holds in the emit state.
`timescale 1ns / 1ps
`default_nettype none
`include "odd_even_partition_defines.svh"

module odd_even_partition
    import oep_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     word_valid,
    output logic                          word_ready,
    input  wire logic signed [WORD_W-1:0] word,
    input  wire logic                     is_last,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic signed      [WORD_W-1:0] word_res,
    output logic                          end_of_run,
    output logic                          overflowed
);

    localparam int AW = $clog2(DEPTH);      // buffer index width
    localparam int CW = $clog2(DEPTH + 1);  // fill count width, holds DEPTH

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_TEST,
        S_SWAP_HI,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     lo_reg, lo_next;     // left pointer, also emit index
    logic [AW-1:0]     hi_reg, hi_next;     // right pointer

    // buffer port signals
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [WORD_W-1:0] rd_a;
    logic [WORD_W-1:0] rd_b;
    logic              run_end;

    // assertion terms
    logic              scan_in_run;
    logic              last_take;
    logic              load_clean;

    oep_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (lo_reg),
        .rd_addr_b (hi_reg),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // last word of the run is at index cnt - 1
    assign run_end = ((CW'(lo_reg) + CW'(1)) == cnt_reg);

    // Reads and writes never overlap on one entry: the scan read, the low
    // write and the high write sit in separate states, so no forwarding.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        wr_en      = 1'b0;
        wr_addr    = lo_reg;
        wr_data    = rd_b;
        rd_en      = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (word_valid)
                begin
                    if (cnt_reg < CW'(DEPTH))
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[AW-1:0];
                        wr_data  = $unsigned(word);
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        // buffer full: drop and flag
                        ovf_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        lo_next    = '0;
                        hi_next    = AW'(cnt_next - CW'(1));
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (lo_reg < hi_reg)
                begin
                    // fetch both pointed-to words
                    rd_en      = 1'b1;
                    state_next = S_TEST;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = S_EMIT_RD;
                end
            end

            S_TEST:
            begin
                priority if (rd_a[0])
                begin
                    lo_next    = lo_reg + AW'(1);
                    state_next = S_SCAN;
                end
                else if (!rd_b[0])
                begin
                    hi_next    = hi_reg - AW'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    // even on the left, odd on the right: low half of the swap
                    wr_en      = 1'b1;
                    wr_addr    = lo_reg;
                    wr_data    = rd_b;
                    state_next = S_SWAP_HI;
                end
            end

            S_SWAP_HI:
            begin
                wr_en      = 1'b1;
                wr_addr    = hi_reg;
                wr_data    = rd_a;
                lo_next    = lo_reg + AW'(1);
                hi_next    = hi_reg - AW'(1);
                state_next = S_SCAN;
            end

            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (res_ready)
                begin
                    if (run_end)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        lo_next    = lo_reg + AW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
        end
    end

    assign word_ready = (state_reg == S_LOAD);
    assign res_valid  = (state_reg == S_EMIT_OUT);
    assign word_res   = $signed(rd_a);   // read data holds until the next read
    assign end_of_run = run_end;
    assign overflowed = ovf_reg;

    assign scan_in_run = (state_reg != S_SCAN) || (CW'(hi_reg) < cnt_reg);
    assign last_take   = res_valid && res_ready && end_of_run;
    assign load_clean  = word_ready && (cnt_reg == '0) && !ovf_reg;

    `OEP_ASSERT(a_phase_excl, clk, rst_n, !(word_ready && res_valid), "load and emit overlap")
    `OEP_ASSERT(a_fill_bound, clk, rst_n, cnt_reg <= CW'(DEPTH), "fill count above depth")
    `OEP_ASSERT(a_scan_bound, clk, rst_n, scan_in_run, "right pointer past fill")
    `OEP_ASSERT_NEXT(a_run_clear, clk, rst_n, last_take, load_clean, "run state not cleared")

endmodule

`default_nettype wire

/* src/oep_mem.sv */
// Word buffer: one write port, two read ports, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oep_mem
    import oep_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr_a,
    input  wire logic [AW-1:0]     rd_addr_b,
    output logic      [WORD_W-1:0] rd_data_a,
    output logic      [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while rd_en is low
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

/* test/odd_even_partition_tb.sv */
// Self-checking testbench for odd_even_partition: random runs, stalls, overflow.
`timescale 1ns / 1ps

module odd_even_partition_tb;
    import oep_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RUN_ITEMS   = 410;   // stop adding random runs past this many words
    localparam int TAIL_CYCLES = 300;   // quiet time after the last result
    localparam int IDLE_LIMIT  = 4000;  // cycles without any handshake before giving up

    // One word waiting to be sent. gap = idle cycles before it goes out;
    // drain = hold it back until every expected result has been seen.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_last;
        logic [7:0]        gap;
        logic              drain;
    } load_req_t;

    // One expected word of a partitioned run.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              end_flag;
        logic              ovf_flag;
    } part_word_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     word_valid = 1'b0;
    logic                     word_ready;
    logic signed [WORD_W-1:0] word       = '0;
    logic                     is_last    = 1'b0;
    logic                     res_valid;
    logic                     res_ready  = 1'b0;
    logic signed [WORD_W-1:0] word_res;
    logic                     end_of_run;
    logic                     overflowed;

    load_req_t  load_q[$];         // words still to be sent
    part_word_t partitioned_q[$];  // results the block still owes us

    // Shadow of the block's storage
    logic [WORD_W-1:0] shadow_buf [DEPTH];
    int                shadow_fill = 0;
    logic              shadow_ovf  = 1'b0;

    int         mismatches = 0;
    int         gap_cnt    = 0;
    int         stall_left = 0;
    int         idle_cnt   = 0;
    logic       stall_calm = 1'b0;
    logic       drive_now;
    load_req_t  next_req;
    part_word_t got_exp;

    odd_even_partition #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word),
        .is_last    (is_last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .word_res   (word_res),
        .end_of_run (end_of_run),
        .overflowed (overflowed)
    );

    // 50 MHz clock
    always #10 clk = ~clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random word shaped by a parity mode:
    // 0 free, 1 forced odd, 2 forced even, 3 mostly odd.
    function automatic logic [WORD_W-1:0] pick_word(input int parity);
        logic [WORD_W-1:0] w;
        int                kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            w = $urandom;
        else if (kind < 8)
            w = $urandom_range(0, 40) - 20;
        else
        begin
            case ($urandom_range(0, 3))
                0:       w = 32'h7FFF_FFFF;
                1:       w = 32'h8000_0000;
                2:       w = 32'hFFFF_FFFF;
                default: w = 32'h0000_0000;
            endcase
            w = w ^ $urandom_range(0, 1);
        end
        case (parity)
            1: w[0] = 1'b1;
            2: w[0] = 1'b0;
            3: w[0] = ($urandom_range(0, 3) != 0);
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_word(input logic [WORD_W-1:0] w, input logic last,
                              input int gap, input logic drain);
        load_req_t r;
        r.word    = w;
        r.is_last = last;
        r.gap     = gap[7:0];
        r.drain   = drain;
        load_q.push_back(r);
    endtask

    // Store one accepted word; on the last one, partition odd-first with
    // the two-pointer walk and queue the whole run as expected results.
    task automatic absorb_word(input logic [WORD_W-1:0] w, input logic last);
        int                lo;
        int                hi;
        int                k;
        logic [WORD_W-1:0] tmp;
        part_word_t        r;
        if (shadow_fill < DEPTH)
        begin
            shadow_buf[shadow_fill] = w;
            shadow_fill++;
        end
        else
            shadow_ovf = 1'b1;   // buffer full: word dropped, run flagged
        if (last)
        begin
            lo = 0;
            hi = shadow_fill - 1;
            while (lo < hi)
            begin
                while (lo < hi && shadow_buf[lo][0])
                    lo++;
                while (lo < hi && !shadow_buf[hi][0])
                    hi--;
                if (lo < hi)
                begin
                    tmp            = shadow_buf[lo];
                    shadow_buf[lo] = shadow_buf[hi];
                    shadow_buf[hi] = tmp;
                end
            end
            for (k = 0; k < shadow_fill; k++)
            begin
                r.word     = shadow_buf[k];
                r.end_flag = (k == shadow_fill - 1);
                r.ovf_flag = shadow_ovf;
                partitioned_q.push_back(r);
            end
            shadow_fill = 0;
            shadow_ovf  = 1'b0;
        end
    endtask

    // Driver: feeds load_q into the input channel. The model is updated at
    // the edge where a request is taken, from the values still on the port.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            word       <= '0;
            is_last    <= 1'b0;
            gap_cnt    = 0;
        end
        else
        begin
            if (word_valid && word_ready)
                absorb_word(word, is_last);
            // Slot is free when nothing is pending or the pending one just went.
            if (!word_valid || word_ready)
            begin
                drive_now = 1'b0;
                if (load_q.size() != 0)
                begin
                    if (gap_cnt < load_q[0].gap)
                        gap_cnt++;
                    else if (!(load_q[0].drain && partitioned_q.size() != 0))
                    begin
                        next_req  = load_q.pop_front();
                        drive_now = 1'b1;
                        gap_cnt   = 0;
                    end
                end
                word_valid <= drive_now;
                if (drive_now)
                begin
                    word    <= next_req.word;
                    is_last <= next_req.is_last;
                end
            end
        end
    end

    // Monitor: random backpressure on res_ready and in-order field checks.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (partitioned_q.size() == 0)
                begin
                    $error("unexpected result: word_res %0d end_of_run %0b overflowed %0b",
                           word_res, end_of_run, overflowed);
                    mismatches++;
                end
                else
                begin
                    got_exp = partitioned_q.pop_front();
                    if (word_res !== got_exp.word)
                    begin
                        $error("word_res: expected %0d, got %0d",
                               $signed(got_exp.word), word_res);
                        mismatches++;
                    end
                    if (end_of_run !== got_exp.end_flag)
                    begin
                        $error("end_of_run: expected %0b, got %0b",
                               got_exp.end_flag, end_of_run);
                        mismatches++;
                    end
                    if (overflowed !== got_exp.ovf_flag)
                    begin
                        $error("overflowed: expected %0b, got %0b",
                               got_exp.ovf_flag, overflowed);
                        mismatches++;
                    end
                end
            end
            // Switch between stall-free stretches and stalling now and then.
            if ($urandom_range(0, 299) == 0)
                stall_calm = !stall_calm;
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!stall_calm && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: any handshake resets the idle count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_valid && word_ready) || (res_valid && res_ready))
                idle_cnt <= 0;
            else if (idle_cnt >= IDLE_LIMIT)
            begin
                $display("odd_even_partition regression: fail");
                $finish;
            end
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    // Stimulus and end of test
    initial
    begin
        int total;
        int run_idx;
        int len;
        int parity;
        int k;
        logic calm;
        logic drain;

        // Directed: single even word (most negative)
        queue_word(32'h8000_0000, 1'b1, 0, 1'b0);
        // single odd word, -1
        queue_word(32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        // even then odd: needs one swap
        queue_word(32'd2, 1'b0, 0, 1'b0);
        queue_word(32'd1, 1'b1, 0, 1'b0);
        // extremes of the word, mixed parity
        queue_word(32'h7FFF_FFFF, 1'b0, 0, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1, 1'b0);
        queue_word(32'h0000_0000, 1'b0, 0, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0, 0, 1'b0);
        queue_word(32'd1, 1'b0, 2, 1'b0);
        queue_word(32'd2, 1'b0, 0, 1'b0);
        queue_word(32'h8000_0001, 1'b0, 0, 1'b0);
        queue_word(32'h7FFF_FFFE, 1'b1, 0, 1'b0);
        // all odd, negatives included: nothing moves
        queue_word(32'd3, 1'b0, 0, 1'b0);
        queue_word(-32'sd3, 1'b0, 0, 1'b0);
        queue_word(32'd5, 1'b0, 0, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b1, 0, 1'b0);
        // all even: nothing moves
        queue_word(32'd0, 1'b0, 0, 1'b0);
        queue_word(-32'sd2, 1'b0, 0, 1'b0);
        queue_word(32'd4, 1'b0, 0, 1'b0);
        queue_word(32'h8000_0000, 1'b1, 0, 1'b0);

        // Random runs: mostly short, a few near or past capacity.
        // Run 3 exactly fills the buffer; run 7 overflows it, last two words dropped.
        total   = 0;
        run_idx = 0;
        while (total < RUN_ITEMS)
        begin
            if (run_idx == 3)
                len = DEPTH;
            else if (run_idx == 7)
                len = DEPTH + 2;
            else if ($urandom_range(0, 19) == 0)
                len = $urandom_range(DEPTH - 3, DEPTH + 4);
            else
                len = $urandom_range(1, 12);
            parity = $urandom_range(0, 5);
            if (parity > 3)
                parity = 0;
            calm  = ($urandom_range(0, 3) == 0);
            drain = (run_idx == 0) || ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++)
                queue_word(pick_word(parity), k == len - 1, calm ? 0 : pick_gap(),
                           drain && k == 0);
            total += len;
            run_idx++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (load_q.size() != 0 || word_valid)
            @(posedge clk);
        while (partitioned_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("odd_even_partition regression: pass");
        else
            $display("odd_even_partition regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/oep_pkg.sv
src/oep_mem.sv
src/odd_even_partition.sv
test/odd_even_partition_tb.sv
